/* src/frequency_recency_victim_select_assert.svh */
// Assertion macros used by the victim select controller.
`ifndef FREQUENCY_RECENCY_VICTIM_SELECT_ASSERT_SVH
`define FREQUENCY_RECENCY_VICTIM_SELECT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define FRVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frvs: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define FRVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frvs: next-cycle check failed");

`else

`define FRVS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FRVS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/frvs_pkg.sv */
// Shared constants, command codes and control structs for the victim select block.
package frvs_pkg;

    // Default sizes
    localparam int WAYS_DEF       = 16;
    localparam int COUNT_BITS_DEF = 8;
    localparam int TIME_BITS_DEF  = 32;

    // Fixed field widths at the ports
    localparam int CMD_BITS      = 2;
    localparam int WAY_BITS      = 4;
    localparam int CUR_TIME_BITS = 32;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_INVALIDATE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_TOUCH      = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_INSERT     = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_VICTIM     = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic ld_in;      // capture the input transfer
        logic inval;      // clear the addressed way
        logic wr_insert;  // write count one and the stamp
        logic wr_touch;   // write the bumped count and the stamp
        logic rd_way;     // read the addressed way
        logic rd_first;   // start the scan at way zero
        logic rd_next;    // read the following way of the scan
        logic scan_step;  // fold the returned way into the best so far
        logic out_load;   // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        logic                way_ok;
        logic                scan_last;
        logic                out_free;
    } t_dp_status;

endpackage

/* src/frequency_recency_victim_select.sv */
// Top level of the frequency/recency victim select block.
// Replacement state for one cache set: each way holds a saturating use count
// and the stamp of its last touch in a small RAM, with one valid flip-flop per
// way so that reset and invalidate make a way read as count zero, stamp zero.
// One command is in flight at a time. Invalidate and insert write the way
// when decoded; touch reads the way, then writes it back through the RAM's
// separate write port; find victim scans one way per cycle through the RAM
// read port and compares it against the best so far; the
// victim is the lowest count, then the oldest stamp, then the lowest index.
// The result sits in an output register, so a new command is taken while a
// victim result still waits downstream.
module frequency_recency_victim_select
    import frvs_pkg::*;
#(
    parameter int WAYS       = WAYS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CMD_BITS-1:0]      i_command,
    input  logic [WAY_BITS-1:0]      i_way,
    input  logic                     i_is_write,
    input  logic [CUR_TIME_BITS-1:0] i_current_time,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [WAY_BITS-1:0]      o_victim_way
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    frvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    frvs_dp #(
        .WAYS       (WAYS),
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_command),
        .i_way          (i_way),
        .i_is_write     (i_is_write),
        .i_current_time (i_current_time),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_victim_way   (o_victim_way)
    );

endmodule

/* src/frvs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module frvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/frvs_ctrl.sv */
// Sequencing state machine for commands and the victim scan.
`include "frequency_recency_victim_select_assert.svh"

module frvs_ctrl
    import frvs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_TOUCH  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    cmd;
    logic       in_xfer;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Decode state and status into datapath commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    cmd.ld_in = 1'b1;
                    n_state   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_IDLE;
                case (i_status.cmd)
                    CMD_VICTIM: begin
                        cmd.rd_first = 1'b1;
                        n_state      = ST_SCAN;
                    end
                    CMD_INVALIDATE: begin
                        cmd.inval = i_status.way_ok;
                    end
                    CMD_INSERT: begin
                        cmd.wr_insert = i_status.way_ok;
                    end
                    CMD_TOUCH: begin
                        if (i_status.way_ok) begin
                            cmd.rd_way = 1'b1;
                            n_state    = ST_TOUCH;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_TOUCH: begin
                cmd.wr_touch = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_FIN;
                end else begin
                    cmd.rd_next = 1'b1;
                end
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `FRVS_ASSERT_NEXT(a_xfer_decodes, i_clk, i_rst_n, in_xfer, r_state == ST_DECODE)
    `FRVS_ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n,
        (r_state == ST_SCAN) && i_status.scan_last, r_state == ST_FIN)
    `FRVS_ASSERT_NOW(a_load_free, i_clk, i_rst_n, cmd.out_load, (r_state == ST_FIN) && i_status.out_free)
    `FRVS_ASSERT_NOW(a_one_write, i_clk, i_rst_n, 1'b1,
        $onehot0({cmd.inval, cmd.wr_insert, cmd.wr_touch}))

endmodule

/* src/frvs_dp.sv */
// Datapath: way store, touch update, victim compare and result register.
module frvs_dp
    import frvs_pkg::*;
#(
    parameter int WAYS       = WAYS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [CMD_BITS-1:0]      i_command,
    input  logic [WAY_BITS-1:0]      i_way,
    input  logic                     i_is_write,
    input  logic [CUR_TIME_BITS-1:0] i_current_time,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [WAY_BITS-1:0]      o_victim_way
);

    localparam int ADDR_W  = $clog2(WAYS);
    localparam int ENTRY_W = COUNT_BITS + TIME_BITS;

    // Captured input transfer
    logic [CMD_BITS-1:0]  r_cmd;
    logic [ADDR_W-1:0]    r_way_addr;
    logic                 r_way_ok;
    logic                 r_wr;
    logic [TIME_BITS-1:0] r_now;

    // Way validity, read tracking, scan and result state
    logic [WAYS-1:0]       r_valid;
    logic                  r_rd_hit;
    logic [ADDR_W-1:0]     r_scan_idx;
    logic [ADDR_W-1:0]     r_best_idx;
    logic [COUNT_BITS-1:0] r_best_cnt;
    logic [TIME_BITS-1:0]  r_best_stamp;
    logic                  r_out_valid;
    logic [WAY_BITS-1:0]   r_victim_way;

    logic [ADDR_W+WAY_BITS-1:0]        way_ext;
    logic [TIME_BITS+CUR_TIME_BITS-1:0] time_ext;
    logic [ADDR_W+WAY_BITS-1:0]        best_ext;
    logic                              rd_en;
    logic [ADDR_W-1:0]                 rd_addr;
    logic                              wr_en;
    logic [ENTRY_W-1:0]                wr_data;
    logic [ENTRY_W-1:0]                ram_q;
    logic [COUNT_BITS-1:0]             rd_cnt;
    logic [TIME_BITS-1:0]              rd_stamp;
    logic [COUNT_BITS:0]               cnt_sum;
    logic [COUNT_BITS-1:0]             cnt_sat;
    logic                              take;
    logic                              out_free;

    // Fit way and time to the internal widths
    assign way_ext  = {{ADDR_W{1'b0}}, i_way};
    assign time_ext = {{TIME_BITS{1'b0}}, i_current_time};

    // Capture the input transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_cmd      <= i_command;
            r_way_addr <= way_ext[ADDR_W-1:0];
            r_way_ok   <= ({{(32-WAY_BITS){1'b0}}, i_way} < 32'(WAYS));
            r_wr       <= i_is_write;
            r_now      <= time_ext[TIME_BITS-1:0];
        end
    end

    // Select the read address
    assign rd_en   = i_cmd.rd_way || i_cmd.rd_first || i_cmd.rd_next;
    assign rd_addr = i_cmd.rd_way   ? r_way_addr :
                     i_cmd.rd_first ? '0 : r_scan_idx + 1'b1;

    // Unwritten or invalidated ways read as zero
    assign rd_cnt   = r_rd_hit ? ram_q[ENTRY_W-1:TIME_BITS] : '0;
    assign rd_stamp = r_rd_hit ? ram_q[TIME_BITS-1:0] : '0;

    // Bump the count for a touch, holding at the maximum
    assign cnt_sum = {1'b0, rd_cnt} + (r_wr ? (COUNT_BITS+1)'(2) : (COUNT_BITS+1)'(1));
    assign cnt_sat = cnt_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : cnt_sum[COUNT_BITS-1:0];

    assign wr_en   = i_cmd.wr_insert || i_cmd.wr_touch;
    assign wr_data = i_cmd.wr_insert ? {COUNT_BITS'(1), r_now} : {cnt_sat, r_now};

    frvs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WAYS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_way_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    // Track which ways hold written data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.inval) begin
            r_valid[r_way_addr] <= 1'b0;
        end else if (wr_en) begin
            r_valid[r_way_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_hit <= r_valid[rd_addr];
        end
    end

    // Advance the scan index along with the reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_first) begin
            r_scan_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_scan_idx <= r_scan_idx + 1'b1;
        end
    end

    // Keep the lowest count, then the oldest stamp, then the lowest index
    assign take = (r_scan_idx == '0) || (rd_cnt < r_best_cnt) ||
                  ((rd_cnt == r_best_cnt) && (rd_stamp < r_best_stamp));

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && take) begin
            r_best_idx   <= r_scan_idx;
            r_best_cnt   <= rd_cnt;
            r_best_stamp <= rd_stamp;
        end
    end

    // Hold the result until the downstream side takes the transfer
    assign out_free = !r_out_valid || !i_out_stall;
    assign best_ext = {{WAY_BITS{1'b0}}, r_best_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_victim_way <= best_ext[WAY_BITS-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_victim_way = r_victim_way;

    assign o_status.cmd       = r_cmd;
    assign o_status.way_ok    = r_way_ok;
    assign o_status.scan_last = (r_scan_idx == ADDR_W'(WAYS - 1));
    assign o_status.out_free  = out_free;

endmodule

/* test/tb.sv */
// Self-checking testbench for the frequency/recency victim select block.
`timescale 1ns / 100ps

module tb
    import frvs_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_CHUNKS  = 20;
    localparam int CHUNK_ITEMS    = 100;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CMD_BITS-1:0]      i_command = CMD_INVALIDATE;
    logic [WAY_BITS-1:0]      i_way = '0;
    logic                     i_is_write = 1'b0;
    logic [CUR_TIME_BITS-1:0] i_current_time = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [WAY_BITS-1:0]      o_victim_way;

    // Predicted replacement state, one entry per way
    logic [COUNT_BITS_DEF-1:0] way_count [WAYS_DEF];
    logic [TIME_BITS_DEF-1:0]  way_stamp [WAYS_DEF];
    logic [WAY_BITS-1:0]       pending_victims[$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    int  out_stall_left = 0;
    bit  idle_enable = 1'b0;

    frequency_recency_victim_select dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_way          (i_way),
        .i_is_write     (i_is_write),
        .i_current_time (i_current_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_victim_way   (o_victim_way)
    );

    always #5 i_clk = ~i_clk;

    // Pick the lowest count, then the oldest stamp, then the lowest index
    function automatic logic [WAY_BITS-1:0] lowest_rank_way();
        int best;
        best = 0;
        for (int w = 1; w < WAYS_DEF; w++) begin
            if (way_count[w] < way_count[best] ||
                (way_count[w] == way_count[best] && way_stamp[w] < way_stamp[best]))
                best = w;
        end
        return best[WAY_BITS-1:0];
    endfunction

    // Update the predicted state for one accepted command
    task automatic apply_command(input logic [CMD_BITS-1:0] cmd,
                                 input logic [WAY_BITS-1:0] way,
                                 input logic wr,
                                 input logic [CUR_TIME_BITS-1:0] now);
        logic [COUNT_BITS_DEF:0] bumped;
        case (cmd)
            CMD_VICTIM: begin
                pending_victims.push_back(lowest_rank_way());
            end
            CMD_INVALIDATE: begin
                way_count[way] = '0;
                way_stamp[way] = '0;
            end
            CMD_INSERT: begin
                way_count[way] = COUNT_BITS_DEF'(1);
                way_stamp[way] = now[TIME_BITS_DEF-1:0];
            end
            default: begin
                bumped = {1'b0, way_count[way]} +
                         (wr ? (COUNT_BITS_DEF+1)'(2) : (COUNT_BITS_DEF+1)'(1));
                way_count[way] = bumped[COUNT_BITS_DEF] ? '1 : bumped[COUNT_BITS_DEF-1:0];
                way_stamp[way] = now[TIME_BITS_DEF-1:0];
            end
        endcase
    endtask

    // Send one command and wait for its transfer
    task automatic send_command(input logic [CMD_BITS-1:0] cmd,
                                input logic [WAY_BITS-1:0] way,
                                input logic wr,
                                input logic [CUR_TIME_BITS-1:0] now);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_way          <= way;
        i_is_write     <= wr;
        i_current_time <= now;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        apply_command(cmd, way, wr, now);
    endtask

    // Reset state, field extremes, ignored fields and full ties
    task automatic test_directed_cases();
        send_command(CMD_VICTIM, 4'hF, 1'b1, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 4'hF, 1'b1, 32'hFFFF_FFFF);
        send_command(CMD_TOUCH, 4'hF, 1'b1, 32'h0000_0000);
        send_command(CMD_TOUCH, 4'h0, 1'b0, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 4'h7, 1'b0, 32'h0000_0000);
        send_command(CMD_VICTIM, 4'h0, 1'b0, 32'h0000_0000);
        send_command(CMD_INVALIDATE, 4'hF, 1'b1, 32'hFFFF_FFFF);
        send_command(CMD_VICTIM, 4'hA, 1'b1, 32'h5A5A_A5A5);
        // Fill every way with one stamp so the index decides
        for (int w = WAYS_DEF - 1; w >= 0; w--)
            send_command(CMD_INSERT, w[WAY_BITS-1:0], 1'b0, 32'h8000_0001);
        send_command(CMD_VICTIM, 4'h5, 1'b0, 32'h0);
        send_command(CMD_INSERT, 4'h0, 1'b0, 32'h8000_0002);
        send_command(CMD_VICTIM, 4'h0, 1'b1, 32'h0);
    endtask

    // Drive one way into count saturation and check it never wraps
    task automatic test_count_saturation();
        logic [WAY_BITS-1:0]      hot;
        logic [CUR_TIME_BITS-1:0] now;
        hot = WAY_BITS'($urandom_range(0, WAYS_DEF - 1));
        now = $urandom;
        for (int w = 0; w < WAYS_DEF; w++)
            send_command(CMD_INSERT, w[WAY_BITS-1:0], 1'b0, now + w);
        for (int w = 0; w < WAYS_DEF; w++)
            if (w != hot)
                send_command(CMD_TOUCH, w[WAY_BITS-1:0], 1'($urandom_range(0, 1)), $urandom);
        repeat (130) begin
            now = now + $urandom_range(0, 3);
            send_command(CMD_TOUCH, hot, 1'b1, now);
        end
        send_command(CMD_TOUCH, hot, 1'b0, now);
        send_command(CMD_VICTIM, hot, 1'b1, now);
        send_command(CMD_TOUCH, hot, 1'b1, 32'h0);
        send_command(CMD_VICTIM, hot, 1'b0, now);
        send_command(CMD_INVALIDATE, hot, 1'b0, now);
        send_command(CMD_VICTIM, hot, 1'b0, now);
    endtask

    // Mixed traffic in chunks, each with its own stamp pattern and way spread
    task automatic test_random_traffic();
        int                       stamp_mode;
        int                       pick;
        bit                       hot_ways;
        logic [CMD_BITS-1:0]      cmd;
        logic [WAY_BITS-1:0]      way;
        logic [CUR_TIME_BITS-1:0] now;
        logic [CUR_TIME_BITS-1:0] clock_now;
        clock_now = $urandom;
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            stamp_mode  = $urandom_range(0, 3);
            hot_ways    = ($urandom_range(0, 3) == 0);
            idle_enable = (chunk < RANDOM_CHUNKS - 2) && ($urandom_range(0, 3) != 0);
            repeat (CHUNK_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 10)      cmd = CMD_INVALIDATE;
                else if (pick < 50) cmd = CMD_TOUCH;
                else if (pick < 70) cmd = CMD_INSERT;
                else                cmd = CMD_VICTIM;
                way = hot_ways ? WAY_BITS'($urandom_range(0, 1)) :
                                 WAY_BITS'($urandom_range(0, WAYS_DEF - 1));
                case (stamp_mode)
                    0: now = $urandom;
                    1: now = $urandom_range(0, 7);
                    2: begin
                        clock_now = clock_now + $urandom_range(0, 3);
                        now = clock_now;
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0: now = 32'h0000_0000;
                            1: now = 32'h0000_0001;
                            2: now = 32'hFFFF_FFFE;
                            default: now = 32'hFFFF_FFFF;
                        endcase
                    end
                endcase
                send_command(cmd, way, 1'($urandom_range(0, 1)), now);
            end
        end
    endtask

    // Stall the result side in random bursts
    always @(posedge i_clk) begin
        if (out_stall_left > 0) begin
            out_stall_left <= out_stall_left - 1;
            i_out_stall    <= 1'b1;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            out_stall_left <= $urandom_range(0, 13);
            i_out_stall    <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each result transfer with the oldest predicted victim
    always @(posedge i_clk) begin
        logic [WAY_BITS-1:0] expected;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_victims.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual victim_way %0d",
                         $time, o_victim_way);
            end else begin
                expected = pending_victims.pop_front();
                if (o_victim_way !== expected) begin
                    mismatches++;
                    $display("%0t: victim_way mismatch, expected %0d, actual %0d",
                             $time, expected, o_victim_way);
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        for (int w = 0; w < WAYS_DEF; w++) begin
            way_count[w] = '0;
            way_stamp[w] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_enable = 1'b1;
        test_directed_cases();
        test_count_saturation();
        test_random_traffic();

        // Drain outstanding victims, then let the block settle
        i_in_valid <= 1'b0;
        while (pending_victims.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
